### rtl/arpc_pkg.sv
package arpc_pkg;

  // Default table size.
  localparam int CACHE_ENTRIES_DEF = 16;

  // Field widths.
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int ENTRY_W = IP_W + MAC_W;
  localparam int STAT_W  = 3;

  // Action codes of an input item.
  localparam logic ACT_PUT    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_NEW      = 3'd3,
    ST_REPLACED = 3'd4
  } status_t;

  // One input item.
  typedef struct packed {
    logic             action;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } req_t;

  // One result item.
  typedef struct packed {
    status_t          status;
    logic [MAC_W-1:0] mac;
  } res_t;

endpackage

### rtl/arpc_ram.sv
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/arpc_ctrl.sv
module arpc_ctrl import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  req_t req_in,
  output logic idle,
  output logic res_valid,
  input  logic res_take,
  output res_t res
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t                   state_r, state_nxt;
  req_t                     req_r, req_nxt;
  res_t                     res_r, res_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]         cnt_r, cnt_nxt;
  logic                     issue_done_r, issue_done_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         found_idx_r, found_idx_nxt;
  logic [MAC_W-1:0]         found_mac_r, found_mac_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]       ram_wdata;
  logic                     ram_re;
  logic [ENTRY_W-1:0]       ram_rdata;

  logic [IP_W-1:0]          rd_ip;
  logic [MAC_W-1:0]         rd_mac;
  logic                     hit_c, empty_c, last_c;
  logic                     found_any, free_any;
  logic [IDX_W-1:0]         found_idx_c, free_idx_c;
  logic [MAC_W-1:0]         found_mac_c;

  // Entry store: address in the upper bits, MAC in the lower bits.
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  // Compare stage: one entry returned by the memory is checked per cycle.
  assign rd_ip   = ram_rdata[ENTRY_W-1 -: IP_W];
  assign rd_mac  = ram_rdata[MAC_W-1:0];
  assign hit_c   = cmp_vld_r && valid_r[cmp_idx_r] && (rd_ip == req_r.ip);
  assign empty_c = cmp_vld_r && !valid_r[cmp_idx_r];
  assign last_c  = cmp_vld_r && (cmp_idx_r == LAST);

  // The lowest match and the lowest free entry, including this cycle's entry.
  assign found_any   = found_r || hit_c;
  assign found_idx_c = found_r ? found_idx_r : cmp_idx_r;
  assign found_mac_c = found_r ? found_mac_r : rd_mac;
  assign free_any    = free_r || empty_c;
  assign free_idx_c  = free_r ? free_idx_r : cmp_idx_r;

  // Scan sequencer; a put is written back at the end of the scan.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    res_nxt        = res_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    issue_done_nxt = issue_done_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cnt_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    found_mac_nxt  = found_mac_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = {req_r.ip, req_r.mac};
    ram_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt        = req_in;
          cnt_nxt        = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          free_nxt       = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle until the last entry has been requested.
        if (!issue_done_r) begin
          ram_re      = 1'b1;
          cmp_vld_nxt = 1'b1;
          if (cnt_r == LAST) begin
            issue_done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        found_nxt     = found_any;
        found_idx_nxt = found_idx_c;
        found_mac_nxt = found_mac_c;
        free_nxt      = free_any;
        free_idx_nxt  = free_idx_c;
        // Last entry checked: decide, write back a put and form the result.
        if (last_c) begin
          state_nxt = S_RESULT;
          if (req_r.action == ACT_LOOKUP) begin
            res_nxt.status = found_any ? ST_HIT : ST_MISS;
            res_nxt.mac    = found_any ? found_mac_c : '0;
          end else begin
            res_nxt.mac = '0;
            ram_we      = 1'b1;
            if (found_any) begin
              ram_waddr      = found_idx_c;
              res_nxt.status = ST_UPDATED;
            end else if (free_any) begin
              ram_waddr             = free_idx_c;
              valid_nxt[free_idx_c] = 1'b1;
              res_nxt.status        = ST_NEW;
            end else begin
              ram_waddr      = '0;
              res_nxt.status = ST_REPLACED;
            end
          end
        end
      end
      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      issue_done_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      free_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      issue_done_r <= issue_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      free_r       <= free_nxt;
    end
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    cnt_r       <= cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_idx_r <= found_idx_nxt;
    found_mac_r <= found_mac_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;

endmodule

### rtl/arp_address_cache_unit.sv
// Channel  | Ports                                           | Direction
// ---------+-------------------------------------------------+----------
// input    | in_valid, in_stall, in_action, in_ipv4_address,  | in
//          | in_mac_address                                  |
// result   | out_valid, out_stall, out_status, out_mac_found | out
//
// An item taken at the input is scanned against the table: the scan reads one table entry per
// cycle from the single memory read port, each entry read is compared, and the result is
// registered in the controller, then handed to the output register once that is empty or not
// stalled. One item is in work at a time; the input opens in the cycle after that hand-off,
// even while the output register is stalled; a new item waits until the last is handed off.
// Reset clears all valid marks at once; no clearing pass is needed.
module arp_address_cache_unit import arpc_pkg::*; #(
  parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [IP_W-1:0]   in_ipv4_address,
  input  logic [MAC_W-1:0]  in_mac_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] out_status,
  output logic [MAC_W-1:0]  out_mac_found
);

  logic  ctrl_idle;
  logic  res_valid;
  logic  res_take;
  logic  in_accept;
  req_t  req_in;
  res_t  res;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = !ctrl_idle;
  assign req_in    = '{action: in_action, ip: in_ipv4_address, mac: in_mac_address};

  arpc_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .req_in    (req_in),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: loads a finished result whenever it is empty or being drained.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_r.status;
  assign out_mac_found = out_r.mac;

  // An accepted item keeps the input side closed on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input not stalled after an accepted item");

  // Only a lookup hit carries a MAC.
  a_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_HIT)) |-> (out_mac_found == '0))
    else $error("nonzero MAC on a result other than a lookup hit");

  // An open input side means no result is pending inside the controller.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !res_valid)
    else $error("controller idle with a pending result");

  // A pending result that is not taken stays pending.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("pending result dropped or changed");

endmodule

### dv/arp_address_cache_unit_test.sv
module arp_address_cache_unit_test;
  import arpc_pkg::*;

  localparam int TABLE_DEPTH   = CACHE_ENTRIES_DEF;
  localparam int RANDOM_OPS    = 800;
  localparam int STALL_LIMIT   = 2000;
  localparam int QUIET_FIRST   = 5000;
  localparam int QUIET_LAST    = 9000;
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 2) + 4;
  localparam int MAX_REPORTS   = 10;

  // One pending put or lookup. A set drain_first holds it back until every
  // earlier reply has come out.
  typedef struct {
    req_t req;
    bit   drain_first;
  } cache_op_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = ACT_PUT;
  logic [IP_W-1:0]   in_ipv4_address = '0;
  logic [MAC_W-1:0]  in_mac_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [MAC_W-1:0]  out_mac_found;

  cache_op_t       op_queue[$];
  res_t            cache_replies[$];
  logic [IP_W-1:0] known_ips[$];

  // Shadow copy of the cache table.
  logic            shadow_valid[TABLE_DEPTH];
  logic [IP_W-1:0]  shadow_ip[TABLE_DEPTH];
  logic [MAC_W-1:0] shadow_mac[TABLE_DEPTH];

  int  mismatches = 0;
  int  cyc = 0;
  int  idle_cycles = 0;
  bit  quiet;
  bit  tx_accept;
  bit  rx_accept;
  res_t      want;
  cache_op_t next_op;

  arp_address_cache_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_ipv4_address (in_ipv4_address),
    .in_mac_address  (in_mac_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_mac_found   (out_mac_found)
  );

  always #10 clk = ~clk;

  // Apply one put or lookup to the shadow table and return the reply it gives.
  function automatic res_t cache_predict(req_t item);
    int   hit_idx;
    int   free_idx;
    res_t reply;
    hit_idx = -1;
    free_idx = -1;
    // Walk downward so that the lowest match and the lowest free entry win.
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_ip[i] == item.ip) hit_idx = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    reply.mac = '0;
    if (item.action == ACT_LOOKUP) begin
      if (hit_idx >= 0) begin
        reply.status = ST_HIT;
        reply.mac = shadow_mac[hit_idx];
      end else begin
        reply.status = ST_MISS;
      end
    end else if (hit_idx >= 0) begin
      shadow_mac[hit_idx] = item.mac;
      reply.status = ST_UPDATED;
    end else if (free_idx >= 0) begin
      shadow_valid[free_idx] = 1'b1;
      shadow_ip[free_idx] = item.ip;
      shadow_mac[free_idx] = item.mac;
      reply.status = ST_NEW;
    end else begin
      shadow_ip[0] = item.ip;
      shadow_mac[0] = item.mac;
      reply.status = ST_REPLACED;
    end
    return reply;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[MAC_W-1:32] = (MAC_W-32)'($urandom);
    m[31:0] = $urandom;
    return m;
  endfunction

  task automatic queue_op(logic act, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                          bit drain = 1'b0);
    cache_op_t op;
    op.req.action = act;
    op.req.ip = ip;
    op.req.mac = mac;
    op.drain_first = drain;
    op_queue.push_back(op);
    if (act == ACT_PUT) known_ips.push_back(ip);
  endtask

  // Stimulus: directed corner cases, then a random mix of puts and lookups.
  initial begin
    int pick;
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;

    // Empty table, address zero, all-ones address and MAC, update, full table.
    queue_op(ACT_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000);
    queue_op(ACT_PUT, 32'h0000_0000, 48'h0000_0000_0000);
    queue_op(ACT_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    queue_op(ACT_PUT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    queue_op(ACT_LOOKUP, 32'hFFFF_FFFF, 48'hA5A5_5A5A_A5A5);
    queue_op(ACT_PUT, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    queue_op(ACT_LOOKUP, 32'h5555_AAAA, 48'hFFFF_FFFF_FFFF);
    for (int i = 2; i < TABLE_DEPTH; i++) begin
      queue_op(ACT_PUT, {8'h0A, 8'h00, 16'(i)}, rand_mac());
    end
    // Table is full now, so a fresh address takes over entry 0.
    queue_op(ACT_PUT, 32'hC0A8_0101, 48'h0200_DEAD_BEEF);
    queue_op(ACT_LOOKUP, 32'h0000_0000, 48'h0);
    queue_op(ACT_LOOKUP, 32'hC0A8_0101, 48'h0);

    // Random mix; known addresses give updates and hits, fresh ones replace or miss.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        queue_op(ACT_PUT, known_ips[$urandom_range(known_ips.size() - 1)], rand_mac(),
                 n == 0 || n == RANDOM_OPS / 2);
      end else if (pick < 45) begin
        queue_op(ACT_PUT, $urandom, rand_mac(), n == 0 || n == RANDOM_OPS / 2);
      end else if (pick < 80) begin
        queue_op(ACT_LOOKUP, known_ips[$urandom_range(known_ips.size() - 1)], rand_mac(),
                 n == 0 || n == RANDOM_OPS / 2);
      end else begin
        queue_op(ACT_LOOKUP, $urandom, rand_mac(), n == 0 || n == RANDOM_OPS / 2);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every reply to come out, then settle.
    do @(posedge clk);
    while (op_queue.size() != 0 || in_valid || cache_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && cache_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Input driver: hold a stalled item, otherwise offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      tx_accept = in_valid && !in_stall;
      if (tx_accept) begin
        cache_replies.push_back(cache_predict('{in_action, in_ipv4_address, in_mac_address}));
      end
      if (!in_valid || tx_accept) begin
        if (op_queue.size() != 0 && !(!quiet && $urandom_range(99) < 6) &&
            !(op_queue[0].drain_first && cache_replies.size() != 0)) begin
          next_op = op_queue.pop_front();
          in_valid <= 1'b1;
          in_action <= next_op.req.action;
          in_ipv4_address <= next_op.req.ip;
          in_mac_address <= next_op.req.mac;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: compare each accepted reply with the oldest prediction.
  always @(posedge clk) begin
    rx_accept = rst_n && out_valid && !out_stall;
    if (rx_accept) begin
      if (cache_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected reply: status %0d mac %012h", out_status, out_mac_found);
        end
      end else begin
        want = cache_replies.pop_front();
        if (out_status !== want.status || out_mac_found !== want.mac) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Reply mismatch: expected %s mac %012h, got status %0d mac %012h",
                     want.status.name(), want.mac, out_status, out_mac_found);
          end
        end
      end
    end
    out_stall <= !quiet && $urandom_range(99) < 6;
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    quiet = cyc >= QUIET_FIRST && cyc < QUIET_LAST;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

endmodule
